>>> rtl/lcdc_pkg.sv
// shared types, constants and codes of the character lcd nibble controller
package lcdc_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int ROWS_DEF    = 2;
    localparam int OUTQ_DEPTH  = 4;

    localparam int BIT_E  = 6;
    localparam int BIT_RW = 5;
    localparam int BIT_RS = 4;

    localparam logic [3:0] NIB_INIT = 4'h2;

    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY_INC  = 8'h06;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
    localparam logic [7:0] CMD_DISP_CUR   = 8'h0E;
    localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] CMD_DDRAM_HOME = 8'h80;

    localparam logic [6:0] DDRAM_ROW1 = 7'h40;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic       req_type;
        logic [7:0] port_value;
        logic       read_row;
        logic [3:0] read_col;
    } t_req;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] cell_char;
        logic [3:0] cursor_col_now;
        logic       cursor_row_now;
        logic       display_is_on;
        logic       cursor_is_shown;
        logic       nibble_mode;
        logic       init_done;
        logic       last_result;
    } t_res;

    typedef struct packed {
        logic push;
        t_res res;
    } t_push;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LF
    } t_state;

endpackage

>>> rtl/lcdc_ifs.sv
// valid/ready channel interfaces of the character lcd nibble controller
interface lcdc_req_if;
    logic          valid;
    logic          ready;
    lcdc_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcdc_res_if;
    logic          valid;
    logic          ready;
    lcdc_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcdc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lcdc_ram.sv
// generic single-port ram with registered read
module lcdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lcdc_outq.sv
// result queue between the sequencer and the result channel
module lcdc_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcdc_pkg::t_push    i_push,
    output logic               o_space,
    lcdc_res_if.source         o_res
);

    localparam int QW = $clog2(lcdc_pkg::OUTQ_DEPTH);

    lcdc_pkg::t_res r_buf [lcdc_pkg::OUTQ_DEPTH];
    logic [QW-1:0]  r_wptr, r_rptr;
    logic [QW:0]    r_count;
    logic           pop;

    assign o_res.valid = (r_count != '0);
    assign o_res.data  = r_buf[r_rptr];
    assign pop         = o_res.valid && o_res.ready;
    assign o_space     = (int'(r_count) <= lcdc_pkg::OUTQ_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_buf[r_wptr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + QW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QW'(1);
            end
            case ({i_push.push, pop})
                2'b10:   r_count <= r_count + (QW+1)'(1);
                2'b01:   r_count <= r_count - (QW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/lcdc_core.sv
// sequencer: port edge decode, nibble pairing, commands and screen ram access
module lcdc_core #(
    parameter int COLUMNS = lcdc_pkg::COLUMNS_DEF,
    parameter int ROWS    = lcdc_pkg::ROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lcdc_req_if.sink        i_req,
    lcdc_cfg_if.sink        i_cfg,
    input  logic            i_space,
    output lcdc_pkg::t_push o_push
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    lcdc_pkg::t_state r_state, n_state;
    lcdc_pkg::t_req   r_item;

    logic [7:0]       r_prev;
    logic             r_four, n_four;
    logic             r_await, n_await;
    logic [3:0]       r_held, n_held;
    logic             r_init, n_init;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic             r_disp, n_disp;
    logic             r_cur, n_cur;
    logic             r_echo_en;
    logic [DEPTH-1:0] r_valid, n_valid;
    logic             r_rd_ok, n_rd_ok;

    logic             st_exec;
    logic             accept;
    logic             latch;
    logic [3:0]       nib;
    logic             rs;
    logic [7:0]       byte_val;
    logic [RW-1:0]    row_next;
    logic [AW-1:0]    wr_addr, rd_addr, ram_addr;
    logic             rd_in_range;
    logic             ram_we, ram_re;
    logic [7:0]       ram_q;
    logic [6:0]       ddr_addr;
    logic [5:0]       ddr_col;
    logic             ex_echo, ex_crlf;
    logic [7:0]       ex_echo_char;

    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign st_exec     = (r_state == lcdc_pkg::ST_EXEC);

    assign latch    = r_prev[lcdc_pkg::BIT_E] && !r_item.port_value[lcdc_pkg::BIT_E]
                      && !r_item.port_value[lcdc_pkg::BIT_RW];
    assign nib      = r_item.port_value[3:0];
    assign rs       = r_item.port_value[lcdc_pkg::BIT_RS];
    assign byte_val = {r_held, nib};
    assign row_next = (int'(r_row) == ROWS - 1) ? '0 : r_row + RW'(1);
    assign wr_addr  = AW'(int'(r_row) * COLUMNS + int'(r_col));
    assign rd_addr  = AW'(int'(r_item.read_row) * COLUMNS + int'(r_item.read_col));
    assign rd_in_range = (int'(r_item.read_row) < ROWS) && (int'(r_item.read_col) < COLUMNS);
    assign ram_addr = r_item.req_type ? rd_addr : wr_addr;
    assign ddr_addr = byte_val[6:0];

    // step datapath
    always_comb begin
        n_four       = r_four;
        n_await      = r_await;
        n_held       = r_held;
        n_init       = r_init;
        n_col        = r_col;
        n_row        = r_row;
        n_disp       = r_disp;
        n_cur        = r_cur;
        n_valid      = r_valid;
        n_rd_ok      = r_rd_ok;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ex_echo      = 1'b0;
        ex_crlf      = 1'b0;
        ex_echo_char = '0;
        ddr_col      = '0;
        if (st_exec) begin
            if (r_item.req_type) begin
                ram_re  = 1'b1;
                n_rd_ok = rd_in_range && r_valid[rd_addr];
            end else if (latch) begin
                if (!r_four) begin
                    if (!rs && nib == lcdc_pkg::NIB_INIT) begin
                        n_four  = 1'b1;
                        n_await = 1'b0;
                        n_init  = 1'b1;
                    end
                end else if (!r_await) begin
                    n_held  = nib;
                    n_await = 1'b1;
                end else begin
                    n_await = 1'b0;
                    if (rs) begin
                        if (r_echo_en && byte_val == lcdc_pkg::CHAR_LF) begin
                            ex_echo      = 1'b1;
                            ex_crlf      = 1'b1;
                            ex_echo_char = lcdc_pkg::CHAR_CR;
                        end else begin
                            ex_echo      = r_echo_en;
                            ex_echo_char = r_echo_en ? byte_val : '0;
                            if (byte_val == lcdc_pkg::CHAR_LF
                                || byte_val == lcdc_pkg::CHAR_CR) begin
                                n_col = '0;
                                n_row = row_next;
                            end else begin
                                ram_we           = 1'b1;
                                n_valid[wr_addr] = 1'b1;
                                if (int'(r_col) == COLUMNS - 1) begin
                                    n_col = '0;
                                    n_row = row_next;
                                end else begin
                                    n_col = r_col + CW'(1);
                                end
                            end
                        end
                    end else begin
                        unique case (byte_val) inside
                            lcdc_pkg::CMD_CLEAR: begin
                                n_valid = '0;
                                n_col   = '0;
                                n_row   = '0;
                            end
                            lcdc_pkg::CMD_HOME, lcdc_pkg::CMD_DDRAM_HOME: begin
                                n_col = '0;
                                n_row = '0;
                            end
                            lcdc_pkg::CMD_ENTRY_INC: begin
                            end
                            lcdc_pkg::CMD_DISP_ON: begin
                                n_disp = 1'b1;
                                n_cur  = 1'b0;
                            end
                            lcdc_pkg::CMD_DISP_CUR: begin
                                n_disp = 1'b1;
                                n_cur  = 1'b1;
                            end
                            lcdc_pkg::CMD_FUNC_4BIT: begin
                                n_four = 1'b1;
                            end
                            default: begin
                                if (byte_val[7]) begin
                                    if (ddr_addr >= lcdc_pkg::DDRAM_ROW1) begin
                                        n_row   = (ROWS > 1) ? RW'(1) : '0;
                                        ddr_col = ddr_addr[5:0];
                                    end else begin
                                        n_row   = '0;
                                        ddr_col = ddr_addr[5:0];
                                    end
                                    if (int'(ddr_col) > COLUMNS - 1) begin
                                        n_col = CW'(COLUMNS - 1);
                                    end else begin
                                        n_col = CW'(ddr_col);
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lcdc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = lcdc_pkg::ST_EXEC;
                end
            end
            lcdc_pkg::ST_EXEC: begin
                if (r_item.req_type) begin
                    n_state = lcdc_pkg::ST_READ;
                end else if (ex_crlf) begin
                    n_state = lcdc_pkg::ST_LF;
                end else begin
                    n_state = lcdc_pkg::ST_IDLE;
                end
            end
            lcdc_pkg::ST_READ: n_state = lcdc_pkg::ST_IDLE;
            lcdc_pkg::ST_LF:   n_state = lcdc_pkg::ST_IDLE;
            default:           n_state = lcdc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready                = 1'b0;
        o_push.push                = 1'b0;
        o_push.res.echo_valid      = 1'b0;
        o_push.res.echo_char       = '0;
        o_push.res.cell_char       = '0;
        o_push.res.cursor_col_now  = 4'(r_col);
        o_push.res.cursor_row_now  = 1'(r_row);
        o_push.res.display_is_on   = r_disp;
        o_push.res.cursor_is_shown = r_cur;
        o_push.res.nibble_mode     = r_four;
        o_push.res.init_done       = r_init;
        o_push.res.last_result     = 1'b1;
        unique case (r_state)
            lcdc_pkg::ST_IDLE: begin
                i_req.ready = i_space;
            end
            lcdc_pkg::ST_EXEC: begin
                o_push.push                = !r_item.req_type;
                o_push.res.echo_valid      = ex_echo;
                o_push.res.echo_char       = ex_echo_char;
                o_push.res.cursor_col_now  = 4'(n_col);
                o_push.res.cursor_row_now  = 1'(n_row);
                o_push.res.display_is_on   = n_disp;
                o_push.res.cursor_is_shown = n_cur;
                o_push.res.nibble_mode     = n_four;
                o_push.res.init_done       = n_init;
                o_push.res.last_result     = !ex_crlf;
            end
            lcdc_pkg::ST_READ: begin
                o_push.push          = 1'b1;
                o_push.res.cell_char = r_rd_ok ? ram_q : lcdc_pkg::CHAR_SPACE;
            end
            lcdc_pkg::ST_LF: begin
                o_push.push           = 1'b1;
                o_push.res.echo_valid = 1'b1;
                o_push.res.echo_char  = lcdc_pkg::CHAR_LF;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lcdc_pkg::ST_IDLE;
            r_prev    <= '0;
            r_four    <= 1'b0;
            r_await   <= 1'b0;
            r_held    <= '0;
            r_init    <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_disp    <= 1'b0;
            r_cur     <= 1'b0;
            r_echo_en <= 1'b0;
            r_valid   <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (st_exec && !r_item.req_type) begin
                r_prev <= r_item.port_value;
            end
            r_four  <= n_four;
            r_await <= n_await;
            r_held  <= n_held;
            r_init  <= n_init;
            r_col   <= n_col;
            r_row   <= n_row;
            r_disp  <= n_disp;
            r_cur   <= n_cur;
            r_valid <= n_valid;
            r_rd_ok <= n_rd_ok;
            if (i_cfg.valid && i_cfg.ready) begin
                r_echo_en <= i_cfg.data;
            end
        end
    end

    lcdc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (byte_val),
        .o_rdata (ram_q)
    );

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == lcdc_pkg::ST_EXEC))
        else $error("accepted item not executed next cycle");

    a_await_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> r_four)
        else $error("low nibble awaited outside four-bit mode");

    a_mode_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_four == r_init)
        else $error("four-bit mode and init flag disagree");

    a_lf_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcdc_pkg::ST_LF) |-> (r_echo_en && !ram_we && o_push.push))
        else $error("lf transfer without echo or with screen write");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) < COLUMNS)
        else $error("cursor column out of range");

endmodule

>>> rtl/char_lcd_nibble_controller.sv
// top level of the character lcd nibble controller
// usage:
//   i_req carries one item per transfer: a port byte write (req_type 0)
//   or a screen cell read (req_type 1, read_row / read_col).
//   o_res returns the results: one per read, one per write, or two
//   (cr then lf, last_result on the second) for a newline with echo on.
//   i_cfg writes echo_enable and is always ready; the user is to write
//   it only while idle, as the block itself does not enforce this.
// sequence:
//   a write executes in the state after its transfer, where its result is
//   queued; a newline echo adds an lf state, a read a read state for the
//   screen ram registered read port. one item is handled at a time.
// reset:
//   synchronous active low; the cursor, flags and port history clear and
//   a per-cell valid vector makes every cell read as a space at once.
//   the clear command empties the whole valid vector.
// stall:
//   a 4-entry result queue decouples o_res; a new item is taken while
//   results wait as long as two entries are free, otherwise i_req is held.
module char_lcd_nibble_controller #(
    parameter int COLUMNS = lcdc_pkg::COLUMNS_DEF,
    parameter int ROWS    = lcdc_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdc_req_if.sink    i_req,
    lcdc_cfg_if.sink    i_cfg,
    lcdc_res_if.source  o_res
);

    lcdc_pkg::t_push push;
    logic            space;

    lcdc_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .i_space (space),
        .o_push  (push)
    );

    lcdc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_res   (o_res)
    );

endmodule
